// ===== rtl/qmg_pkg.sv =====
`timescale 1ns / 1ps
package qmg_pkg;
	localparam int MAX_COLUMNS   = 256;
	localparam int MAX_ROWS      = 256;
	localparam int FRACTION_BITS = 16;
	localparam int COORD_W       = 32;
	localparam int CFG_W         = 9;
	localparam int IDX_W         = 8;
	localparam int LEN_W         = 33;
	localparam int TOTAL_W       = LEN_W + 3;
	localparam int FAC_W         = TOTAL_W;
	localparam int PROD_W        = 4 * FAC_W;
	localparam int SUM_W         = 2 * COORD_W + 1;
	localparam int RAD_W         = 96;
	localparam int ROOT_W        = RAD_W / 2;
	localparam int MEAS_W        = 48;
	localparam int AREA_SHIFT    = 2 * FRACTION_BITS + 4;
	localparam int COL_AW        = $clog2(MAX_COLUMNS);
	localparam int ROW_W         = $clog2(MAX_ROWS);
	localparam int BIT_W         = $clog2(FAC_W);

	localparam logic [COORD_W-1:0] SIGN_BIT = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic [MEAS_W-1:0] MEAS_MAX  = {MEAS_W{1'b1}};

	localparam logic [1:0] KIND_CELL = 2'd0;
	localparam logic [1:0] KIND_VERT = 2'd1;
	localparam logic [1:0] KIND_HORZ = 2'd2;

	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_SQX, S_SQY, S_SQS, S_GO, S_ROOT, S_EMIT,
		S_SUM, S_FAC, S_MUL, S_ARAD, S_FINISH
	} state_t;

	typedef enum logic [2:0] {
		JOB_LEFT, JOB_UP, JOB_TOP, JOB_SIDE, JOB_AREA
	} job_t;
endpackage

// ===== rtl/qmg_node_if.sv =====
`timescale 1ns / 1ps
interface qmg_node_if;
	import qmg_pkg::*;
	logic valid;
	logic ready;
	logic signed [COORD_W-1:0] node_x;
	logic signed [COORD_W-1:0] node_y;
	modport source (output valid, node_x, node_y, input ready);
	modport sink (input valid, node_x, node_y, output ready);
endinterface

// ===== rtl/qmg_result_if.sv =====
`timescale 1ns / 1ps
interface qmg_result_if;
	import qmg_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [IDX_W-1:0] row_index;
	logic [IDX_W-1:0] column_index;
	logic signed [COORD_W-1:0] center_x;
	logic signed [COORD_W-1:0] center_y;
	logic [MEAS_W-1:0] measure;
	logic last;
	logic grid_end;
	modport source (output valid, kind, row_index, column_index, center_x, center_y,
		measure, last, grid_end, input ready);
	modport sink (input valid, kind, row_index, column_index, center_x, center_y,
		measure, last, grid_end, output ready);
endinterface

// ===== rtl/qmg_ram.sv =====
`timescale 1ns / 1ps
module qmg_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/qmg_sqrt.sv =====
`timescale 1ns / 1ps
module qmg_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [qmg_pkg::RAD_W-1:0] radicand,
	output logic                      done,
	output logic [qmg_pkg::ROOT_W-1:0] root
);
	import qmg_pkg::*;
	localparam int REM_W = ROOT_W + 3;
	localparam int CNT_W = $clog2(ROOT_W);

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [REM_W-1:0] rem_t;
	logic [REM_W-1:0] trial;
	logic take;
	logic last_step;

	assign rem_t = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign take = rem_t >= trial;
	assign last_step = busy_q && (cnt_q == CNT_W'(ROOT_W - 1));
	assign done = done_q;
	assign root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (take) begin
				rem_q <= rem_t - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_t;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/quad_mesh_cell_and_face_geometry.sv =====
`timescale 1ns / 1ps
// Streams mesh nodes in raster order and returns, per node, the edge to the left
// node, the edge to the node above, and the closed cell (centroid and area), in
// that order, with last on the final result of each node. One node is worked at
// a time and node.ready is high only between nodes. A 48-step square root unit
// (one result bit per cycle) and a 36-step shift-add multiplier set how long a
// node takes, and any stall on the result side adds to that time.
module quad_mesh_cell_and_face_geometry (
	input  logic                      clk,
	input  logic                      arst_n,
	qmg_node_if.sink                  node,
	qmg_result_if.source              result,
	input  logic                      cfg_write,
	input  logic                      cfg_index,
	input  logic [qmg_pkg::CFG_W-1:0] cfg_data
);
	import qmg_pkg::*;

	state_t state_q, state_d;
	job_t job_q, job_d;

	logic [CFG_W-1:0] cols_q, rows_q, cols_eff, rows_eff;
	logic [COL_AW-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [COORD_W-1:0] x_q, y_q, up_x_q, up_y_q, left_x_q, left_y_q;
	logic [COORD_W-1:0] upleft_x_q, upleft_y_q;
	logic [2*COORD_W-1:0] mul_q;
	logic [SUM_W-1:0] sum_q;
	logic [LEN_W-1:0] len_q [4];
	logic [TOTAL_W-1:0] total_q;
	logic [PROD_W-1:0] acc_q, mcand_q;
	logic [FAC_W-1:0] mplier_q;
	logic [BIT_W-1:0] bit_q;
	logic [1:0] idx_q;
	logic [MEAS_W-1:0] meas_q;

	logic out_valid_q;
	logic [1:0] out_kind_q;
	logic [IDX_W-1:0] out_row_q, out_col_q;
	logic [COORD_W-1:0] out_cx_q, out_cy_q;
	logic [MEAS_W-1:0] out_meas_q;
	logic out_last_q, out_end_q;

	logic accept, ram_we, sq_start, root_done, emit, sat, grid_last;
	logic [2*COORD_W-1:0] rdata;
	logic [ROOT_W-1:0] root;
	logic [RAD_W-1:0] radicand;
	logic [COORD_W-1:0] pa_x, pa_y, pb_x, pb_y, ma, mb, dsel;
	logic [2*COORD_W-1:0] sq;
	logic [TOTAL_W:0] fdiff;
	logic [FAC_W-1:0] fac;
	logic [1:0] e_kind;
	logic [IDX_W-1:0] e_row, e_col;
	logic [COORD_W-1:0] e_cx, e_cy;
	logic e_last;
	logic [COORD_W:0] m2x, m2y;
	logic [COORD_W+1:0] m4x, m4y;

	function automatic logic [COORD_W-1:0] mag_diff(input logic [COORD_W-1:0] p,
		input logic [COORD_W-1:0] q);
		logic [COORD_W-1:0] bp, bq;
		bp = p ^ SIGN_BIT;
		bq = q ^ SIGN_BIT;
		return (bp >= bq) ? bp - bq : bq - bp;
	endfunction

	assign cols_eff = (cols_q < CFG_W'(2)) ? CFG_W'(2) :
		(cols_q > CFG_W'(MAX_COLUMNS)) ? CFG_W'(MAX_COLUMNS) : cols_q;
	assign rows_eff = (rows_q < CFG_W'(2)) ? CFG_W'(2) :
		(rows_q > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_q;
	assign grid_last = ({1'b0, row_q} == rows_eff - 1'b1) &&
		({1'b0, col_q} == cols_eff - 1'b1);

	assign accept = node.valid && node.ready;

	qmg_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_COLUMNS)) u_line (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q),
		.wdata ({x_q, y_q}),
		.raddr (col_q),
		.rdata (rdata)
	);

	assign radicand = (job_q == JOB_AREA) ? acc_q[AREA_SHIFT+RAD_W-1:AREA_SHIFT] :
		{{(RAD_W-SUM_W){1'b0}}, sum_q};
	assign sat = |acc_q[PROD_W-1:AREA_SHIFT+RAD_W];

	qmg_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.done     (root_done),
		.root     (root)
	);

	always_comb begin
		unique case (job_q)
			JOB_LEFT: begin
				pa_x = left_x_q; pa_y = left_y_q; pb_x = x_q; pb_y = y_q;
			end
			JOB_UP: begin
				pa_x = up_x_q; pa_y = up_y_q; pb_x = x_q; pb_y = y_q;
			end
			JOB_TOP: begin
				pa_x = upleft_x_q; pa_y = upleft_y_q; pb_x = up_x_q; pb_y = up_y_q;
			end
			default: begin
				pa_x = upleft_x_q; pa_y = upleft_y_q; pb_x = left_x_q; pb_y = left_y_q;
			end
		endcase
	end

	assign dsel = (state_q == S_SQX) ? mag_diff(pa_x, pb_x) : mag_diff(pa_y, pb_y);
	assign sq = dsel * dsel;

	assign fdiff = {1'b0, total_q} - {3'b000, len_q[idx_q], 1'b0};
	assign fac = fdiff[TOTAL_W] ? '0 : fdiff[FAC_W-1:0];

	assign ma = (job_q == JOB_LEFT) ? left_x_q : up_x_q;
	assign mb = (job_q == JOB_LEFT) ? left_y_q : up_y_q;
	assign m2x = {1'b0, ma ^ SIGN_BIT} + {1'b0, x_q ^ SIGN_BIT};
	assign m2y = {1'b0, mb ^ SIGN_BIT} + {1'b0, y_q ^ SIGN_BIT};
	assign m4x = {2'b00, upleft_x_q ^ SIGN_BIT} + {2'b00, up_x_q ^ SIGN_BIT}
		+ {2'b00, left_x_q ^ SIGN_BIT} + {2'b00, x_q ^ SIGN_BIT};
	assign m4y = {2'b00, upleft_y_q ^ SIGN_BIT} + {2'b00, up_y_q ^ SIGN_BIT}
		+ {2'b00, left_y_q ^ SIGN_BIT} + {2'b00, y_q ^ SIGN_BIT};

	always_comb begin
		unique case (job_q)
			JOB_LEFT: begin
				e_kind = KIND_HORZ;
				e_row = IDX_W'(row_q);
				e_col = IDX_W'(col_q - 1'b1);
				e_cx = m2x[COORD_W:1] ^ SIGN_BIT;
				e_cy = m2y[COORD_W:1] ^ SIGN_BIT;
				e_last = (row_q == '0);
			end
			JOB_UP: begin
				e_kind = KIND_VERT;
				e_row = IDX_W'(row_q - 1'b1);
				e_col = IDX_W'(col_q);
				e_cx = m2x[COORD_W:1] ^ SIGN_BIT;
				e_cy = m2y[COORD_W:1] ^ SIGN_BIT;
				e_last = (col_q == '0);
			end
			default: begin
				e_kind = KIND_CELL;
				e_row = IDX_W'(row_q - 1'b1);
				e_col = IDX_W'(col_q - 1'b1);
				e_cx = m4x[COORD_W+1:2] ^ SIGN_BIT;
				e_cy = m4y[COORD_W+1:2] ^ SIGN_BIT;
				e_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q <= JOB_LEFT;
		end else begin
			state_q <= state_d;
			job_q <= job_d;
		end
	end

	always_comb begin
		state_d = state_q;
		job_d = job_q;
		node.ready = 1'b0;
		ram_we = 1'b0;
		sq_start = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				node.ready = 1'b1;
				if (node.valid) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				ram_we = 1'b1;
				if (col_q != '0) begin
					job_d = JOB_LEFT;
					state_d = S_SQX;
				end else if (row_q != '0) begin
					job_d = JOB_UP;
					state_d = S_SQX;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SQX: state_d = S_SQY;
			S_SQY: state_d = S_SQS;
			S_SQS: state_d = S_GO;
			S_GO: begin
				sq_start = 1'b1;
				state_d = S_ROOT;
			end
			S_ROOT: begin
				if (root_done) begin
					unique case (job_q)
						JOB_TOP: begin
							job_d = JOB_SIDE;
							state_d = S_SQX;
						end
						JOB_SIDE: begin
							job_d = JOB_AREA;
							state_d = S_SUM;
						end
						default: state_d = S_EMIT;
					endcase
				end
			end
			S_EMIT: begin
				if (!out_valid_q || result.ready) begin
					emit = 1'b1;
					state_d = S_FINISH;
					if (job_q == JOB_LEFT && row_q != '0) begin
						job_d = JOB_UP;
						state_d = S_SQX;
					end else if (job_q == JOB_UP && col_q != '0) begin
						job_d = JOB_TOP;
						state_d = S_SQX;
					end
				end
			end
			S_SUM: state_d = S_FAC;
			S_FAC: begin
				if (idx_q != '0) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				if (bit_q == BIT_W'(FAC_W - 1)) begin
					state_d = (idx_q == 2'd3) ? S_ARAD : S_FAC;
				end
			end
			S_ARAD: begin
				if (sat) begin
					state_d = S_EMIT;
				end else begin
					sq_start = 1'b1;
					state_d = S_ROOT;
				end
			end
			S_FINISH: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					x_q <= node.node_x;
					y_q <= node.node_y;
				end
			end
			S_LOAD: begin
				up_x_q <= rdata[2*COORD_W-1:COORD_W];
				up_y_q <= rdata[COORD_W-1:0];
			end
			S_SQX: mul_q <= sq;
			S_SQY: begin
				sum_q <= {1'b0, mul_q};
				mul_q <= sq;
			end
			S_SQS: sum_q <= sum_q + {1'b0, mul_q};
			S_ROOT: begin
				if (root_done) begin
					meas_q <= MEAS_W'(root);
					if (job_q != JOB_AREA) begin
						len_q[job_q[1:0]] <= root[LEN_W-1:0];
					end
				end
			end
			S_SUM: begin
				total_q <= {3'b000, len_q[0]} + {3'b000, len_q[1]}
					+ {3'b000, len_q[2]} + {3'b000, len_q[3]};
				idx_q <= '0;
			end
			S_FAC: begin
				if (idx_q == '0) begin
					acc_q <= {{(PROD_W-FAC_W){1'b0}}, fac};
					idx_q <= 2'd1;
				end else begin
					mcand_q <= acc_q;
					mplier_q <= fac;
					acc_q <= '0;
					bit_q <= '0;
				end
			end
			S_MUL: begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= {mcand_q[PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[FAC_W-1:1]};
				bit_q <= bit_q + 1'b1;
				if (bit_q == BIT_W'(FAC_W - 1)) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_ARAD: begin
				if (sat) begin
					meas_q <= MEAS_MAX;
				end
			end
			S_FINISH: begin
				left_x_q <= x_q;
				left_y_q <= y_q;
				upleft_x_q <= up_x_q;
				upleft_y_q <= up_y_q;
			end
			default: ;
		endcase
		if (emit) begin
			out_kind_q <= e_kind;
			out_row_q <= e_row;
			out_col_q <= e_col;
			out_cx_q <= e_cx;
			out_cy_q <= e_cy;
			out_meas_q <= meas_q;
			out_last_q <= e_last;
			out_end_q <= grid_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CFG_W'(2);
			rows_q <= CFG_W'(2);
			col_q <= '0;
			row_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				unique case (cfg_index)
					REG_COLUMNS: cols_q <= cfg_data;
					REG_ROWS: rows_q <= cfg_data;
					default: ;
				endcase
				col_q <= '0;
				row_q <= '0;
			end else if (state_q == S_FINISH) begin
				if ({1'b0, col_q} + 1'b1 >= cols_eff) begin
					col_q <= '0;
					row_q <= ({1'b0, row_q} + 1'b1 >= rows_eff) ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.kind = out_kind_q;
	assign result.row_index = out_row_q;
	assign result.column_index = out_col_q;
	assign result.center_x = out_cx_q;
	assign result.center_y = out_cy_q;
	assign result.measure = out_meas_q;
	assign result.last = out_last_q;
	assign result.grid_end = out_end_q;

	a_root_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == S_ROOT)
		else $error("root result outside wait state");

	a_last_ends_node: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && e_last) |=> state_q == S_FINISH && result.valid && result.last)
		else $error("node not closed after its final result");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < cols_eff && {1'b0, row_q} < rows_eff)
		else $error("position outside grid");
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import qmg_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 1500;
	localparam int SETTLE_CYCLES  = 20;
	localparam int NUM_DIRECTED   = 20;
	localparam int NUM_PHASES     = 5;

	typedef struct packed {
		logic [1:0]         kind;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [MEAS_W-1:0]  meas;
		logic               last;
		logic               gend;
	} geom_t;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		bit                 typed;
		geom_t              exp_geom;
	} node_row_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_data;

	qmg_node_if   node_ch();
	qmg_result_if res_ch();

	quad_mesh_cell_and_face_geometry u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.node      (node_ch),
		.result    (res_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	geom_t geom_q[$];
	logic [COORD_W-1:0] line_x[MAX_COLUMNS];
	logic [COORD_W-1:0] line_y[MAX_COLUMNS];
	logic [COORD_W-1:0] prev_x, prev_y, diag_x, diag_y;
	int unsigned pos_col, pos_row, num_cols, num_rows;
	int errors, nodes_sent, geoms_seen, cells_seen;
	int snd_idle, rcv_stall;
	bit hold_req;
	bit hold_used = 1'b0;
	int hold_cnt = 0;
	int quiet_cycles = 0;
	node_row_t dir_tab[NUM_DIRECTED];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [47:0] isqrt(input logic [95:0] v);
		logic [47:0] r;
		logic [47:0] c;
		logic [95:0] cw;
		r = '0;
		for (int b = 47; b >= 0; b--) begin
			c = r | (48'd1 << b);
			cw = c;
			if (cw * cw <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic logic [MEAS_W-1:0] span_len(input logic [31:0] x1, y1, x2, y2);
		logic signed [32:0] dx, dy;
		logic [95:0] ax, ay;
		dx = $signed({x1[31], x1}) - $signed({x2[31], x2});
		dy = $signed({y1[31], y1}) - $signed({y2[31], y2});
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		return isqrt(ax * ax + ay * ay);
	endfunction

	function automatic logic [31:0] mid2(input logic [31:0] p, q);
		logic signed [33:0] t;
		t = $signed({{2{p[31]}}, p}) + $signed({{2{q[31]}}, q});
		t = t >>> 1;
		return t[31:0];
	endfunction

	function automatic logic [31:0] mid4(input logic [31:0] p, q, r, s);
		logic signed [33:0] t;
		t = $signed({{2{p[31]}}, p}) + $signed({{2{q[31]}}, q})
			+ $signed({{2{r[31]}}, r}) + $signed({{2{s[31]}}, s});
		t = t >>> 2;
		return t[31:0];
	endfunction

	function automatic logic [MEAS_W-1:0] quad_area(input logic [MEAS_W-1:0] a, b, c, d);
		logic signed [51:0] tot, f;
		logic [MEAS_W-1:0] sides[4];
		logic [143:0] prod;
		sides[0] = a;
		sides[1] = b;
		sides[2] = c;
		sides[3] = d;
		tot = $signed({4'b0, a}) + $signed({4'b0, b}) + $signed({4'b0, c})
			+ $signed({4'b0, d});
		prod = 144'd1;
		for (int i = 0; i < 4; i++) begin
			f = tot - 2 * $signed({4'b0, sides[i]});
			if (f < 0)
				f = 0;
			prod = prod * f[51:0];
		end
		prod = prod >> AREA_SHIFT;
		if (prod[143:96] != '0)
			return MEAS_MAX;
		return isqrt(prod[95:0]);
	endfunction

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < 2)
			return 2;
		return v > hi ? hi : v;
	endfunction

	task automatic predict_node(input logic [31:0] x, y, input bit typed, input geom_t tg);
		int unsigned cols, nrows, c, r;
		logic [31:0] ux, uy;
		logic [MEAS_W-1:0] l_left, l_up, l_top, l_side;
		geom_t g[3];
		int n;
		cols = clamp_dim(num_cols, MAX_COLUMNS);
		nrows = clamp_dim(num_rows, MAX_ROWS);
		c = pos_col >= cols ? 0 : pos_col;
		r = pos_row >= nrows ? 0 : pos_row;
		ux = line_x[c];
		uy = line_y[c];
		n = 0;
		if (c > 0) begin
			l_left = span_len(prev_x, prev_y, x, y);
			g[n] = '{KIND_HORZ, r[7:0], 8'(c - 1), mid2(prev_x, x), mid2(prev_y, y),
				l_left, 1'b0, 1'b0};
			n++;
		end
		if (r > 0) begin
			l_up = span_len(ux, uy, x, y);
			g[n] = '{KIND_VERT, 8'(r - 1), c[7:0], mid2(ux, x), mid2(uy, y),
				l_up, 1'b0, 1'b0};
			n++;
		end
		if (r > 0 && c > 0) begin
			l_top = span_len(diag_x, diag_y, ux, uy);
			l_side = span_len(diag_x, diag_y, prev_x, prev_y);
			g[n] = '{KIND_CELL, 8'(r - 1), 8'(c - 1), mid4(diag_x, ux, prev_x, x),
				mid4(diag_y, uy, prev_y, y), quad_area(l_top, l_side, l_left, l_up),
				1'b0, 1'b0};
			n++;
		end
		if (n > 0) begin
			g[n-1].last = 1'b1;
			if (r == nrows - 1 && c == cols - 1)
				for (int i = 0; i < n; i++)
					g[i].gend = 1'b1;
		end
		if (typed)
			geom_q = {geom_q, tg};
		else
			for (int i = 0; i < n; i++)
				geom_q = {geom_q, g[i]};
		diag_x = ux;
		diag_y = uy;
		line_x[c] = x;
		line_y[c] = y;
		prev_x = x;
		prev_y = y;
		c++;
		if (c >= cols) begin
			c = 0;
			r++;
			if (r >= nrows)
				r = 0;
		end
		pos_col = c;
		pos_row = r;
	endtask

	task automatic send_node(input logic [31:0] x, y, input bit typed, input geom_t tg);
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle) begin
			node_ch.valid = 1'b0;
			@(negedge clk);
		end
		node_ch.valid = 1'b1;
		node_ch.node_x = x;
		node_ch.node_y = y;
		do @(posedge clk); while (!node_ch.ready);
		predict_node(x, y, typed, tg);
		nodes_sent++;
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		node_ch.valid = 1'b0;
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_write = 1'b0;
		if (idx == REG_COLUMNS)
			num_cols = int'(val);
		else
			num_rows = int'(val);
		pos_col = 0;
		pos_row = 0;
	endtask

	task automatic drain();
		@(negedge clk);
		node_ch.valid = 1'b0;
		while (geom_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic report(input string field, input logic [63:0] got, exp_v);
		$display("mismatch %s: got %0h, want %0h (result %0d)", field, got, exp_v,
			geoms_seen);
		errors++;
	endtask

	function automatic logic [31:0] rand_coord();
		logic [31:0] v;
		v = $urandom;
		if ($urandom_range(0, 7) != 0)
			v = $signed(v) >>> $urandom_range(0, 24);
		return v;
	endfunction

	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			res_ch.ready <= 1'b0;
		end else if (hold_req && !hold_used) begin
			hold_used <= 1'b1;
			hold_cnt <= HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= $urandom_range(0, 99) >= rcv_stall;
		end
	end

	always @(posedge clk) begin
		geom_t w;
		if (res_ch.valid && res_ch.ready) begin
			if (geom_q.size() == 0) begin
				report("unexpected result", res_ch.kind, '0);
			end else begin
				w = geom_q.pop_front();
				if (res_ch.kind != w.kind) report("kind", res_ch.kind, w.kind);
				if (res_ch.row_index != w.row) report("row_index", res_ch.row_index, w.row);
				if (res_ch.column_index != w.col)
					report("column_index", res_ch.column_index, w.col);
				if (res_ch.center_x != w.cx) report("center_x", res_ch.center_x, w.cx);
				if (res_ch.center_y != w.cy) report("center_y", res_ch.center_y, w.cy);
				if (res_ch.measure != w.meas) report("measure", res_ch.measure, w.meas);
				if (res_ch.last != w.last) report("last", res_ch.last, w.last);
				if (res_ch.grid_end != w.gend) report("grid_end", res_ch.grid_end, w.gend);
				if (w.kind == KIND_CELL)
					cells_seen++;
			end
			geoms_seen++;
		end
		if ((res_ch.valid && res_ch.ready) || (node_ch.valid && node_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic fill_table();
		geom_t z;
		logic [31:0] hi, lo;
		z = '0;
		hi = 32'h7fffffff;
		lo = 32'h80000000;
		dir_tab[0]  = '{32'd0, 32'd0, 0, z};
		dir_tab[1]  = '{32'd65536, 32'd0, 1,
			'{KIND_HORZ, 8'd0, 8'd0, 32'd32768, 32'd0, 48'd65536, 1'b1, 1'b0}};
		dir_tab[2]  = '{32'd0, 32'd65536, 1,
			'{KIND_VERT, 8'd0, 8'd0, 32'd0, 32'd32768, 48'd65536, 1'b1, 1'b0}};
		dir_tab[3]  = '{32'd65536, 32'd65536, 0, z};
		dir_tab[4]  = '{hi, hi, 0, z};
		dir_tab[5]  = '{lo, lo, 0, z};
		dir_tab[6]  = '{lo, hi, 0, z};
		dir_tab[7]  = '{hi, lo, 0, z};
		dir_tab[8]  = '{32'd5, 32'd5, 0, z};
		dir_tab[9]  = '{32'd5, 32'd5, 1,
			'{KIND_HORZ, 8'd0, 8'd0, 32'd5, 32'd5, 48'd0, 1'b1, 1'b0}};
		dir_tab[10] = '{32'd5, 32'd5, 1,
			'{KIND_VERT, 8'd0, 8'd0, 32'd5, 32'd5, 48'd0, 1'b1, 1'b0}};
		dir_tab[11] = '{32'd5, 32'd5, 0, z};
		dir_tab[12] = '{32'd0, 32'd0, 0, z};
		dir_tab[13] = '{32'd4, 32'd0, 0, z};
		dir_tab[14] = '{32'd1, 32'd0, 0, z};
		dir_tab[15] = '{32'd3, 32'd0, 0, z};
		dir_tab[16] = '{-32'sd3, -32'sd1, 0, z};
		dir_tab[17] = '{-32'sd2, -32'sd1, 1,
			'{KIND_HORZ, 8'd0, 8'd0, -32'sd3, -32'sd1, 48'd1, 1'b1, 1'b0}};
		dir_tab[18] = '{-32'sd3, 32'd0, 0, z};
		dir_tab[19] = '{-32'sd2, 32'd0, 0, z};
	endtask

	initial begin
		int ph_cols[NUM_PHASES]  = '{5, 0, 511, 7, 2};
		int ph_rows[NUM_PHASES]  = '{4, 1, 2, 511, 256};
		int ph_items[NUM_PHASES] = '{40, 12, 270, 100, 40};
		int ph_idle[NUM_PHASES]  = '{0, 69, 0, 30, 0};
		int ph_stall[NUM_PHASES] = '{0, 0, 69, 30, 0};
		geom_t z;
		z = '0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_COLUMNS;
		cfg_data = '0;
		node_ch.valid = 1'b0;
		node_ch.node_x = '0;
		node_ch.node_y = '0;
		hold_req = 1'b0;
		errors = 0;
		nodes_sent = 0;
		geoms_seen = 0;
		cells_seen = 0;
		snd_idle = 0;
		rcv_stall = 0;
		for (int i = 0; i < MAX_COLUMNS; i++) begin
			line_x[i] = '0;
			line_y[i] = '0;
		end
		prev_x = '0;
		prev_y = '0;
		diag_x = '0;
		diag_y = '0;
		pos_col = 0;
		pos_row = 0;
		num_cols = 2;
		num_rows = 2;
		fill_table();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NUM_DIRECTED; i++)
			send_node(dir_tab[i].x, dir_tab[i].y, dir_tab[i].typed, dir_tab[i].exp_geom);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_reg(REG_COLUMNS, CFG_W'(ph_cols[p]));
			write_reg(REG_ROWS, CFG_W'(ph_rows[p]));
			snd_idle = ph_idle[p];
			rcv_stall = ph_stall[p];
			for (int i = 0; i < ph_items[p]; i++) begin
				if (p == 2 && i == 20)
					hold_req = 1'b1;
				send_node(rand_coord(), rand_coord(), 0, z);
			end
			drain();
		end

		repeat (400) @(posedge clk);
		$display("covered %0d nodes, %0d results (%0d cells) over %0d grid settings",
			nodes_sent, geoms_seen, cells_seen, NUM_PHASES + 1);
		if (geom_q.size() != 0) begin
			$display("%0d expected results never arrived", geom_q.size());
			errors++;
		end
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule
